// ===== rtl/mrpt_pkg.sv =====
// Package: shared constants and witness table for the Miller-Rabin prime test.
`timescale 1ns / 1ps
package mrpt_pkg;
  localparam int NUM_WIDTH_DEF = 64;
  localparam int NUM_BASES = 12;
  localparam int BASE_IDX_W = 4;
  localparam int BASE_W = 6;

  // Return the witness base for a table index.
  function automatic logic [BASE_W-1:0] base_at(input logic [BASE_IDX_W-1:0] idx);
    logic [BASE_W-1:0] b;
    begin
      unique case (idx)
        4'd0: b = 6'd2;
        4'd1: b = 6'd3;
        4'd2: b = 6'd5;
        4'd3: b = 6'd7;
        4'd4: b = 6'd11;
        4'd5: b = 6'd13;
        4'd6: b = 6'd17;
        4'd7: b = 6'd19;
        4'd8: b = 6'd23;
        4'd9: b = 6'd29;
        4'd10: b = 6'd31;
        4'd11: b = 6'd37;
        default: b = 6'd37;
      endcase
      return b;
    end
  endfunction
endpackage

// ===== rtl/mrpt_modmul.sv =====
// Bit-serial modular multiplier: one shift-and-add step per cycle.
`timescale 1ns / 1ps
module mrpt_modmul import mrpt_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [NUM_WIDTH-1:0] a,
  input  logic [NUM_WIDTH-1:0] b,
  input  logic [NUM_WIDTH-1:0] m,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] prod
);
  localparam int CNT_W = $clog2(NUM_WIDTH);

  logic [NUM_WIDTH-1:0] opa;
  logic [NUM_WIDTH-1:0] opb;
  logic [NUM_WIDTH-1:0] acc;
  logic [CNT_W-1:0]     cnt;
  logic                 run;
  logic [NUM_WIDTH-1:0] dbl;
  logic [NUM_WIDTH-1:0] acc_next;

  // Double the accumulator mod m, then add a when the top multiplier bit is set.
  always_comb begin
    logic [NUM_WIDTH-1:0] room;
    logic [NUM_WIDTH-1:0] room2;
    room = m - acc;
    dbl = (acc >= room) ? (acc - room) : (acc + acc);
    room2 = m - opa;
    if (opb[NUM_WIDTH-1]) begin
      acc_next = (dbl >= room2) ? (dbl - room2) : (dbl + opa);
    end else begin
      acc_next = dbl;
    end
  end

  // Step through the multiplier bits, most significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        opa <= a;
        opb <= b;
        acc <= '0;
        cnt <= CNT_W'(NUM_WIDTH - 1);
      end else if (run) begin
        acc <= acc_next;
        opb <= opb << 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule

// ===== rtl/miller_rabin_prime_test.sv =====
// Top level: Miller-Rabin sequencer around a shared bit-serial modular multiplier.
`timescale 1ns / 1ps
// Tests one candidate at a time for primality. Pulse start while busy is low;
// busy rises on the next cycle and stays high until is_prime is presented with
// done for exactly one cycle, which the receiver must take. Each modular
// multiplication runs on one shared shift-and-add unit; a candidate needs up to
// twelve bases times about 2*NUM_WIDTH multiplications, so roughly 1500
// multiplications at NUM_WIDTH of 64 for a large prime and none for even or
// tiny values.
module miller_rabin_prime_test import mrpt_pkg::*; #(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] candidate,
  output logic        busy,
  output logic        done,
  output logic        is_prime
);
  localparam int S_W = $clog2(NUM_WIDTH + 1);

  typedef enum logic [3:0] {
    IDLE, SPLIT, BASE, POW_MUL, POW_SQR, POW_NEXT, CHECK, SQR, SQR_CHECK, FINISH
  } state_t;

  state_t               state;
  logic [NUM_WIDTH-1:0] n;
  logic [NUM_WIDTH-1:0] nm1;
  logic [NUM_WIDTH-1:0] d;
  logic [NUM_WIDTH-1:0] e;
  logic [S_W-1:0]       s;
  logic [S_W-1:0]       r;
  logic [NUM_WIDTH-1:0] x;
  logic [NUM_WIDTH-1:0] sq;
  logic [BASE_IDX_W-1:0] k;
  logic                 verdict;
  logic                 mul_go;
  logic [NUM_WIDTH-1:0] mul_a;
  logic [NUM_WIDTH-1:0] mul_b;
  logic                 mul_done;
  logic [NUM_WIDTH-1:0] mul_p;
  logic [NUM_WIDTH-1:0] base_ext;
  logic [NUM_WIDTH-1:0] cand_w;

  assign cand_w = candidate[NUM_WIDTH-1:0];
  assign base_ext = NUM_WIDTH'(base_at(k));

  mrpt_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b), .m(n),
    .done(mul_done), .prod(mul_p)
  );

  // Sequence the test and drive the shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      is_prime <= 1'b0;
      mul_go <= 1'b0;
    end else begin
      done <= 1'b0;
      mul_go <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            n <= cand_w;
            nm1 <= cand_w - 1'b1;
            d <= cand_w - 1'b1;
            s <= '0;
            k <= '0;
            busy <= 1'b1;
            if (cand_w < NUM_WIDTH'(2)) begin
              verdict <= 1'b0;
              state <= FINISH;
            end else if (cand_w == NUM_WIDTH'(2) || cand_w == NUM_WIDTH'(3)) begin
              verdict <= 1'b1;
              state <= FINISH;
            end else if (!cand_w[0]) begin
              verdict <= 1'b0;
              state <= FINISH;
            end else begin
              state <= SPLIT;
            end
          end
        end
        SPLIT: begin
          // Strip factors of two from n-1, one per cycle.
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + 1'b1;
          end else begin
            state <= BASE;
          end
        end
        BASE: begin
          if (k == BASE_IDX_W'(NUM_BASES) || n <= base_ext) begin
            verdict <= 1'b1;
            state <= FINISH;
          end else begin
            x <= NUM_WIDTH'(1);
            sq <= base_ext;
            e <= d;
            state <= POW_NEXT;
          end
        end
        POW_NEXT: begin
          if (e == '0) begin
            state <= CHECK;
          end else if (e[0]) begin
            mul_a <= x;
            mul_b <= sq;
            mul_go <= 1'b1;
            state <= POW_MUL;
          end else begin
            mul_a <= sq;
            mul_b <= sq;
            mul_go <= 1'b1;
            state <= POW_SQR;
          end
        end
        POW_MUL: begin
          if (mul_done) begin
            x <= mul_p;
            mul_a <= sq;
            mul_b <= sq;
            mul_go <= 1'b1;
            state <= POW_SQR;
          end
        end
        POW_SQR: begin
          if (mul_done) begin
            sq <= mul_p;
            e <= e >> 1;
            state <= POW_NEXT;
          end
        end
        CHECK: begin
          r <= S_W'(1);
          if (x == NUM_WIDTH'(1) || x == nm1) begin
            k <= k + 1'b1;
            state <= BASE;
          end else begin
            state <= SQR_CHECK;
          end
        end
        SQR_CHECK: begin
          if (r >= s) begin
            verdict <= 1'b0;
            state <= FINISH;
          end else begin
            mul_a <= x;
            mul_b <= x;
            mul_go <= 1'b1;
            state <= SQR;
          end
        end
        SQR: begin
          if (mul_done) begin
            x <= mul_p;
            r <= r + 1'b1;
            if (mul_p == nm1) begin
              k <= k + 1'b1;
              state <= BASE;
            end else begin
              state <= SQR_CHECK;
            end
          end
        end
        FINISH: begin
          done <= 1'b1;
          is_prime <= verdict;
          busy <= 1'b0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A result appears only while an item is in flight.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without busy item");
  // Busy drops exactly when the result is shown.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy fell without result");
  // The multiplier is only launched while busy.
  assert property (@(posedge clk) disable iff (rst) mul_go |-> busy)
    else $error("multiplier launched while idle");
endmodule

// ===== sim/miller_rabin_prime_test_tb.sv =====
// Testbench for the Miller-Rabin prime test: directed and random candidates checked by a scoreboard.
`timescale 1ns / 1ps
module miller_rabin_prime_test_tb;
  import mrpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 350;
  localparam int DRAIN_CYCLES = 20;

  // Hold the expected primality verdicts and check results against them.
  class prime_scoreboard;
    bit verdict_q[$];
    int errors;
    int primes_seen;
    int composites_seen;

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) % {64'd0, m};
      return prod[63:0];
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1 % m;
      sq = b % m;
      while (e != 64'd0) begin
        if (e[0]) acc = mulmod(acc, sq, m);
        sq = mulmod(sq, sq, m);
        e = e >> 1;
      end
      return acc;
    endfunction

    function automatic bit predict_prime(logic [63:0] n);
      logic [63:0] d, x, nm1, a;
      int s;
      bit hit;
      s = 0;
      if (n < 64'd2) return 1'b0;
      if (n == 64'd2 || n == 64'd3) return 1'b1;
      if (!n[0]) return 1'b0;
      nm1 = n - 64'd1;
      d = nm1;
      while (!d[0]) begin
        d = d >> 1;
        s++;
      end
      for (int k = 0; k < NUM_BASES; k++) begin
        a = {58'd0, base_at(k[BASE_IDX_W-1:0])};
        if (n <= a) break;
        x = powmod(a, d, n);
        if (x == 64'd1 || x == nm1) continue;
        hit = 1'b0;
        for (int r = 1; r < s; r++) begin
          x = mulmod(x, x, n);
          if (x == nm1) begin
            hit = 1'b1;
            break;
          end
        end
        if (!hit) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(logic [63:0] n);
      bit v;
      v = predict_prime(n);
      verdict_q.push_back(v);
      if (v) primes_seen++;
      else composites_seen++;
    endfunction

    function void check_result(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual is_prime=%0b", $time, got);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        $display("%0t: is_prime mismatch: expected %0b, actual %0b", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] candidate = 64'd0;
  logic        busy;
  logic        done;
  logic        is_prime;

  prime_scoreboard sb = new();
  int idle_cycles = 0;
  int items_sent = 0;

  miller_rabin_prime_test i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .candidate(candidate),
    .busy(busy),
    .done(done),
    .is_prime(is_prime)
  );

  always #1 clk = ~clk;

  // Check each presented result.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(is_prime);
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 40);
  endfunction

  // Present one item after a gap and hold it until accepted.
  task automatic send_item(logic [63:0] n, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    candidate <= n;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(n);
    items_sent++;
  endtask

  // Build a random candidate, mostly cheap to test.
  function automatic logic [63:0] random_candidate();
    logic [63:0] v;
    int sel;
    int w;
    v = {$urandom(), $urandom()};
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      v[0] = 1'b0;
    end else if (sel < 50) begin
      v = v & 64'h3f;
    end else if (sel < 88) begin
      w = $urandom_range(8, 20);
      v = (v & ((64'd1 << w) - 64'd1)) | 64'd1;
    end else begin
      v[0] = 1'b1;
    end
    return v;
  endfunction

  logic [63:0] directed [] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd31, 64'd37, 64'd41,
    64'd49, 64'd561, 64'd25326001, 64'd3215031751, 64'd4294967311,
    64'd3825123056546413051, 64'h1fffffffffffffff, 64'hffffffffffffffc5,
    64'hffffffffffffffff, 64'hfffffffffffffffe, 64'h8000000000000000,
    64'h8000000000000001, 64'h5555555555555555, 64'haaaaaaaaaaaaaaab
  };

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i], pick_gap());
    for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_candidate(), pick_gap());
    start <= 1'b0;
    // Drain outstanding results, then let the bench idle quietly before the summary.
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Tested %0d candidates: %0d prime, %0d composite or below two.",
             items_sent, sb.primes_seen, sb.composites_seen);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/mrpt_pkg.sv
rtl/mrpt_modmul.sv
rtl/miller_rabin_prime_test.sv
sim/miller_rabin_prime_test_tb.sv
